// ----- rtl/b248_pkg.sv -----
package b248_pkg;

    localparam int SYM_FIELDS     = 7;
    localparam int MAX_DIGITS_DEF = 7;
    localparam int SUM_W          = 56;

    localparam logic [7:0]  RADIX      = 8'd248;
    // ceil(2^34 / 31): exact quotient by 31 for operands below 2^29
    localparam logic [29:0] RECIP      = 30'd554189329;
    localparam logic [7:0]  SPACE_BYTE = 8'h20;
    localparam logic [7:0]  ZERO_BYTE  = 8'h01;

    // item bookkeeping that rides along the digit chain
    typedef struct packed {
        logic [2:0]                 len;
        logic                       zero;
        logic [SYM_FIELDS-1:0][7:0] dig;
        logic [SYM_FIELDS-1:0]      spc;
    } meta_t;

    // partly divided number: top chunk, middle quotient, last chunk in flight
    typedef struct packed {
        logic [7:0]  c0;
        logic [23:0] q1;
        logic [31:0] v2;
        logic [58:0] p2;
    } part_t;

    function automatic logic [SUM_W-1:0] half_of(input logic [2:0] len);
        logic [SUM_W-1:0] h;
        case (len)
            3'd1:    h = 56'd124;
            3'd2:    h = 56'd30752;
            3'd3:    h = 56'd7626496;
            3'd4:    h = 56'd1891371008;
            3'd5:    h = 56'd469060009984;
            3'd6:    h = 56'd116326882476032;
            3'd7:    h = 56'd28849066854055936;
            default: h = '0;
        endcase
        return h;
    endfunction

    // product of (v / 8) and the reciprocal of 31
    function automatic logic [58:0] mul_recip(input logic [31:0] v);
        return 59'(v[31:3]) * 59'(RECIP);
    endfunction

    function automatic logic [23:0] quot(input logic [58:0] p);
        return p[57:34];
    endfunction

    function automatic logic [7:0] rem248(input logic [31:0] v, input logic [23:0] q);
        logic [31:0] r;
        r = v - {q, 8'd0} + {5'd0, q, 3'd0};
        return r[7:0];
    endfunction

    function automatic logic [SUM_W-1:0] part_num(input part_t p);
        return {p.c0, p.q1, quot(p.p2)};
    endfunction

    function automatic logic [7:0] part_digit(input part_t p);
        return rem248(p.v2, quot(p.p2));
    endfunction

    function automatic logic [7:0] digit_to_byte(input logic [7:0] d);
        logic [7:0] b;
        if (d < 8'd31)
            b = d + 8'd1;
        else if (d == 8'd31)
            b = 8'd34;
        else if (d <= 8'd120)
            b = d + 8'd5;
        else
            b = d + 8'd7;
        return b;
    endfunction

endpackage

// ----- rtl/b248_num_if.sv -----
interface b248_num_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [2:0]         digit_count;

    modport source (output valid, value, digit_count, input ready);
    modport sink   (input valid, value, digit_count, output ready);
endinterface

// ----- rtl/b248_sym_if.sv -----
interface b248_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] sym_0;
    logic [7:0] sym_1;
    logic [7:0] sym_2;
    logic [7:0] sym_3;
    logic [7:0] sym_4;
    logic [7:0] sym_5;
    logic [7:0] sym_6;
    logic [2:0] used_count;

    modport source (output valid, sym_0, sym_1, sym_2, sym_3, sym_4, sym_5, sym_6,
                    used_count, input ready);
    modport sink   (input valid, sym_0, sym_1, sym_2, sym_3, sym_4, sym_5, sym_6,
                    used_count, output ready);
endinterface

// ----- rtl/base248_offset_number_encoder.sv -----
// Offset base-248 number encoder.
//
// number  : input beats carry a signed 64-bit value and a digit count L.
// symbols : one output beat per input beat, in order: L character bytes in
//           sym_0 (most significant) onwards, unused fields zero, and
//           used_count = L (saturated at MAX_DIGITS).
// Both channels use valid/ready; a beat moves when both are high.
//
// Throughput: one beat per cycle while symbols is ready.
// Two clamp stages, then two stages per digit, each holding one 29x30
// reciprocal multiply of the divide-by-248 chain, then the output register.
//
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When symbols stalls, the output register holds its beat and the stages
// behind it keep filling bubbles; number.ready drops only once every stage
// holds a beat. Nothing is dropped or repeated.
module base248_offset_number_encoder
    import b248_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    b248_num_if.sink     number,
    b248_sym_if.source   symbols
);

    logic [MAX_DIGITS:0]        ch_valid;
    logic [MAX_DIGITS:0]        ch_ready;
    meta_t                      ch_meta [0:MAX_DIGITS];
    part_t                      ch_part [0:MAX_DIGITS];
    logic [SYM_FIELDS-1:0][7:0] sym;

    b248_clamp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_clamp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (number.valid),
        .in_ready    (number.ready),
        .value       (number.value),
        .digit_count (number.digit_count),
        .out_valid   (ch_valid[0]),
        .out_ready   (ch_ready[0]),
        .out_meta    (ch_meta[0]),
        .out_part    (ch_part[0])
    );

    generate
        for (genvar i = 0; i < MAX_DIGITS; i++)
        begin : g_digit
            b248_digit #(
                .IDX (i)
            ) u_digit (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (ch_valid[i]),
                .in_ready  (ch_ready[i]),
                .in_meta   (ch_meta[i]),
                .in_part   (ch_part[i]),
                .out_valid (ch_valid[i+1]),
                .out_ready (ch_ready[i+1]),
                .out_meta  (ch_meta[i+1]),
                .out_part  (ch_part[i+1])
            );
        end
    endgenerate

    b248_format #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_format (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (ch_valid[MAX_DIGITS]),
        .in_ready   (ch_ready[MAX_DIGITS]),
        .in_meta    (ch_meta[MAX_DIGITS]),
        .in_part    (ch_part[MAX_DIGITS]),
        .out_valid  (symbols.valid),
        .out_ready  (symbols.ready),
        .sym        (sym),
        .used_count (symbols.used_count)
    );

    assign symbols.sym_0 = sym[0];
    assign symbols.sym_1 = sym[1];
    assign symbols.sym_2 = sym[2];
    assign symbols.sym_3 = sym[3];
    assign symbols.sym_4 = sym[4];
    assign symbols.sym_5 = sym[5];
    assign symbols.sym_6 = sym[6];

endmodule

// ----- rtl/b248_clamp.sv -----
module b248_clamp
    import b248_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic [2:0]  digit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output meta_t       out_meta,
    output part_t       out_part
);

    logic             s1_valid_reg;
    logic [2:0]       s1_len_reg;
    logic             s1_neg_reg;
    logic [63:0]      s1_mag_reg;
    logic [SUM_W-1:0] s1_half_reg;

    logic [2:0]       s1_len_next;
    logic [63:0]      s1_mag_next;

    logic             s2_valid_reg;
    meta_t            s2_meta_reg;
    part_t            s2_part_reg;
    meta_t            s2_meta_next;
    part_t            s2_part_next;

    logic             s1_ready;
    logic             s2_ready;
    logic             over;
    logic             eq;
    logic [SUM_W-1:0] mag_c;
    logic [SUM_W-1:0] sum;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_len_next = (digit_count > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digit_count;
        s1_mag_next = value[63] ? (~value + 64'd1) : value;
    end

    always_comb
    begin
        over  = s1_mag_reg > {8'd0, s1_half_reg};
        eq    = s1_mag_reg == {8'd0, s1_half_reg};
        mag_c = over ? s1_half_reg : s1_mag_reg[SUM_W-1:0];
        sum   = s1_neg_reg ? (s1_half_reg - mag_c) : (s1_half_reg + mag_c);

        s2_meta_next      = '0;
        s2_meta_next.len  = s1_len_reg;
        s2_meta_next.zero = s1_neg_reg && (over || eq);

        // sum loaded as if its low chunk were a finished quotient
        s2_part_next.c0 = sum[55:48];
        s2_part_next.q1 = sum[47:24];
        s2_part_next.v2 = '0;
        s2_part_next.p2 = {1'b0, sum[23:0], 34'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_len_reg  <= s1_len_next;
            s1_neg_reg  <= value[63];
            s1_mag_reg  <= s1_mag_next;
            s1_half_reg <= half_of(s1_len_next);
        end
        if (s2_ready)
        begin
            s2_meta_reg <= s2_meta_next;
            s2_part_reg <= s2_part_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_meta  = s2_meta_reg;
    assign out_part  = s2_part_reg;

endmodule

// ----- rtl/b248_digit.sv -----
module b248_digit
    import b248_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  meta_t in_meta,
    input  part_t in_part,
    output logic  out_valid,
    input  logic  out_ready,
    output meta_t out_meta,
    output part_t out_part
);

    logic [SUM_W-1:0] num;
    meta_t            a_meta_next;
    logic             a_q0_next;
    logic [7:0]       r0;
    logic [31:0]      a_v1_next;

    logic             a_valid_reg;
    meta_t            a_meta_reg;
    logic             a_q0_reg;
    logic [31:0]      a_v1_reg;
    logic [58:0]      a_p1_reg;
    logic [23:0]      a_c2_reg;

    logic [23:0]      q1;
    logic [7:0]       r1;
    part_t            b_part_next;

    logic             b_valid_reg;
    meta_t            b_meta_reg;
    part_t            b_part_reg;

    logic             a_ready;
    logic             b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // finish the previous digit: its last quotient closes the number
    assign num = part_num(in_part);

    generate
        if (IDX > 0)
        begin : g_fin
            always_comb
            begin
                a_meta_next              = in_meta;
                a_meta_next.dig[IDX-1]   = part_digit(in_part);
                a_meta_next.spc[IDX]     = (num == '0);
            end
        end
        else
        begin : g_first
            assign a_meta_next = in_meta;
        end
    endgenerate

    always_comb
    begin
        a_q0_next = num[55:48] >= RADIX;
        r0        = a_q0_next ? (num[55:48] - RADIX) : num[55:48];
        a_v1_next = {r0, num[47:24]};
    end

    always_comb
    begin
        q1             = quot(a_p1_reg);
        r1             = rem248(a_v1_reg, q1);
        b_part_next.c0 = {7'd0, a_q0_reg};
        b_part_next.q1 = q1;
        b_part_next.v2 = {r1, a_c2_reg};
        b_part_next.p2 = mul_recip({r1, a_c2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_meta_reg <= a_meta_next;
            a_q0_reg   <= a_q0_next;
            a_v1_reg   <= a_v1_next;
            a_p1_reg   <= mul_recip(a_v1_next);
            a_c2_reg   <= num[23:0];
        end
        if (b_ready)
        begin
            b_meta_reg <= a_meta_reg;
            b_part_reg <= b_part_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_meta  = b_meta_reg;
    assign out_part  = b_part_reg;

endmodule

// ----- rtl/b248_format.sv -----
module b248_format
    import b248_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  meta_t                      in_meta,
    input  part_t                      in_part,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SYM_FIELDS-1:0][7:0] sym,
    output logic [2:0]                 used_count
);

    meta_t                      meta;
    logic [2:0]                 k;
    logic [SYM_FIELDS-1:0][7:0] sym_next;

    logic                       out_valid_reg;
    logic [SYM_FIELDS-1:0][7:0] sym_reg;
    logic [2:0]                 used_reg;

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        meta                      = in_meta;
        meta.dig[MAX_DIGITS-1]    = part_digit(in_part);
        k                         = '0;
        for (int p = 0; p < SYM_FIELDS; p++)
        begin
            sym_next[p] = '0;
            if (3'(p) < meta.len)
            begin
                // field p holds digit k counted from the least significant end
                k = meta.len - 3'(p) - 3'd1;
                if (meta.zero)
                    sym_next[p] = ZERO_BYTE;
                else if (k != 3'd0 && meta.spc[k])
                    sym_next[p] = SPACE_BYTE;
                else
                    sym_next[p] = digit_to_byte(meta.dig[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            sym_reg  <= sym_next;
            used_reg <= in_meta.len;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sym        = sym_reg;
    assign used_count = used_reg;

endmodule

// ----- rtl/b248_checker.sv -----
module b248_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] sym_0,
    input logic [7:0] sym_1,
    input logic [7:0] sym_2,
    input logic [7:0] sym_3,
    input logic [7:0] sym_4,
    input logic [7:0] sym_5,
    input logic [7:0] sym_6,
    input logic [2:0] used_count
);

    // a stalled beat keeps its characters
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({sym_0, sym_1, sym_2, sym_3, sym_4, sym_5,
                                              sym_6, used_count}))
        else $error("output beat changed while stalled");

    // the leading character is never a null byte
    a_lead: assert property (@(posedge clk) disable iff (!rst_n)
        valid && used_count != 3'd0 |-> sym_0 != 8'd0)
        else $error("leading character is zero");

    // the last field stays clear unless all seven characters are used
    a_tail: assert property (@(posedge clk) disable iff (!rst_n)
        valid && used_count != 3'd7 |-> sym_6 == 8'd0)
        else $error("unused trailing field not zero");

    // pipeline comes out of reset empty
    a_rst: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !valid)
        else $error("output valid straight after reset");

endmodule

bind base248_offset_number_encoder b248_checker u_b248_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (symbols.valid),
    .ready      (symbols.ready),
    .sym_0      (symbols.sym_0),
    .sym_1      (symbols.sym_1),
    .sym_2      (symbols.sym_2),
    .sym_3      (symbols.sym_3),
    .sym_4      (symbols.sym_4),
    .sym_5      (symbols.sym_5),
    .sym_6      (symbols.sym_6),
    .used_count (symbols.used_count)
);
